// ===== rtl/core/bws_pkg.sv =====
// shared types and constants for the bus watchdog safety supervisor
package bws_pkg;

    localparam int unsigned CfgWidth  = 16;
    localparam int unsigned TickWidth = 32;

    typedef enum logic [1:0] {
        REG_TIMEOUT_LIMIT    = 2'd0,
        REG_RELEASE_DEBOUNCE = 2'd1,
        REG_BLINK_PERIOD     = 2'd2,
        REG_RETRY_INTERVAL   = 2'd3
    } cfg_index_t;

    localparam logic [CfgWidth-1:0] TimeoutLimitReset    = 16'd5000;
    localparam logic [CfgWidth-1:0] ReleaseDebounceReset = 16'd50;
    localparam logic [CfgWidth-1:0] BlinkPeriodReset     = 16'd500;
    localparam logic [CfgWidth-1:0] RetryIntervalReset   = 16'd500;

    localparam logic [1:0] RetractNone    = 2'd0;
    localparam logic [1:0] RetractSuccess = 2'd1;
    localparam logic [1:0] RetractFailure = 2'd2;

    typedef struct packed {
        logic                 tick_elapsed;
        logic                 estop_button;
        logic                 bus_frame_seen;
        logic [1:0]           retract_status;
    } item_t;

    typedef struct packed {
        logic [TickWidth-1:0] tick_count;
        logic                 stop_latched;
        logic                 timeout_flag;
        logic                 led_level;
    } timer_status_t;

    typedef struct packed {
        logic relay_on;
        logic safety_mode;
        logic request_retract;
        logic request_stop_all;
        logic request_close;
        logic at_safe_position;
    } mode_out_t;

endpackage

// ===== rtl/core/bws_timers.sv =====
// tick counter, bus silence watchdog, emergency stop debounce and led blinker
module bws_timers (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 step,
    input  bws_pkg::item_t                       item,
    input  logic [bws_pkg::CfgWidth-1:0]         timeout_limit,
    input  logic [bws_pkg::CfgWidth-1:0]         release_debounce,
    input  logic [bws_pkg::CfgWidth-1:0]         blink_period,
    output bws_pkg::timer_status_t               status
);

    logic [bws_pkg::TickWidth-1:0] tick_count_reg, tick_count_next;
    logic [bws_pkg::CfgWidth-1:0]  silence_count_reg, silence_count_next;
    logic                          timeout_flag_reg, timeout_flag_next;
    logic                          stop_latched_reg, stop_latched_next;
    logic [bws_pkg::TickWidth-1:0] release_mark_reg, release_mark_next;
    logic [bws_pkg::TickWidth-1:0] blink_mark_reg, blink_mark_next;
    logic                          led_level_reg, led_level_next;

    logic [bws_pkg::CfgWidth-1:0]  silence_inc;
    logic [bws_pkg::TickWidth-1:0] release_dist;
    logic [bws_pkg::TickWidth-1:0] blink_dist;

    always_comb begin
        tick_count_next    = tick_count_reg + {{(bws_pkg::TickWidth-1){1'b0}}, item.tick_elapsed};
        silence_count_next = silence_count_reg;
        timeout_flag_next  = timeout_flag_reg;
        stop_latched_next  = stop_latched_reg;
        release_mark_next  = release_mark_reg;
        blink_mark_next    = blink_mark_reg;
        led_level_next     = led_level_reg;

        silence_inc  = silence_count_reg + {{(bws_pkg::CfgWidth-1){1'b0}}, 1'b1};
        release_dist = tick_count_next - release_mark_reg;
        blink_dist   = tick_count_next - blink_mark_reg;

        if (item.tick_elapsed) begin
            if (silence_inc >= timeout_limit) begin
                silence_count_next = timeout_limit;
                timeout_flag_next  = 1'b1;
            end else begin
                silence_count_next = silence_inc;
            end
        end

        if (item.estop_button) begin
            stop_latched_next = 1'b1;
            release_mark_next = tick_count_next;
        end else if (release_dist >= {{(bws_pkg::TickWidth-bws_pkg::CfgWidth){1'b0}},
                                      release_debounce}) begin
            stop_latched_next = 1'b0;
        end

        if (stop_latched_next) begin
            if (blink_dist >= {{(bws_pkg::TickWidth-bws_pkg::CfgWidth){1'b0}},
                               blink_period}) begin
                blink_mark_next = tick_count_next;
                led_level_next  = ~led_level_reg;
            end
        end else begin
            led_level_next = 1'b1;
        end

        // frame from host clears the watchdog
        if (item.bus_frame_seen) begin
            silence_count_next = '0;
            timeout_flag_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_count_reg    <= '0;
            silence_count_reg <= '0;
            timeout_flag_reg  <= 1'b0;
            stop_latched_reg  <= 1'b0;
            release_mark_reg  <= '0;
            blink_mark_reg    <= '0;
            led_level_reg     <= 1'b0;
        end else if (step) begin
            tick_count_reg    <= tick_count_next;
            silence_count_reg <= silence_count_next;
            timeout_flag_reg  <= timeout_flag_next;
            stop_latched_reg  <= stop_latched_next;
            release_mark_reg  <= release_mark_next;
            blink_mark_reg    <= blink_mark_next;
            led_level_reg     <= led_level_next;
        end
    end

    assign status.tick_count   = tick_count_next;
    assign status.stop_latched = stop_latched_next;
    assign status.timeout_flag = timeout_flag_next;
    assign status.led_level    = led_level_next;

    a_timeout_needs_silence: assert property (@(posedge aclk) disable iff (!aresetn)
        step && item.bus_frame_seen |=> !timeout_flag_reg && silence_count_reg == '0)
        else $error("frame did not clear watchdog");

    a_press_latches: assert property (@(posedge aclk) disable iff (!aresetn)
        step && item.estop_button |=> stop_latched_reg && release_mark_reg == tick_count_reg)
        else $error("button press not latched");

endmodule

// ===== rtl/core/bws_mode.sv =====
// normal and safety mode machine with relay, retract and retry control
module bws_mode (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step,
    input  bws_pkg::timer_status_t        status,
    input  logic [1:0]                    retract_status,
    input  logic [bws_pkg::CfgWidth-1:0]  retry_interval,
    output bws_pkg::mode_out_t            result
);

    typedef enum logic {
        MODE_NORMAL = 1'b0,
        MODE_SAFETY = 1'b1
    } mode_t;

    mode_t                         mode_reg, mode_next;
    logic                          relay_level_reg, relay_level_next;
    logic                          retracted_flag_reg, retracted_flag_next;
    logic [bws_pkg::TickWidth-1:0] retry_due_reg, retry_due_next;
    logic                          attempt_pending_reg, attempt_pending_next;
    logic                          controller_opened_reg, controller_opened_next;
    logic                          req_retract, req_stop, req_close;
    logic                          fault;

    always_comb begin
        mode_next              = mode_reg;
        relay_level_next       = relay_level_reg;
        retracted_flag_next    = retracted_flag_reg;
        retry_due_next         = retry_due_reg;
        attempt_pending_next   = attempt_pending_reg;
        controller_opened_next = controller_opened_reg;
        req_retract            = 1'b0;
        req_stop               = 1'b0;
        req_close              = 1'b0;
        fault                  = status.stop_latched || status.timeout_flag;

        unique case (mode_reg)
            MODE_NORMAL: begin
                if (fault) begin
                    mode_next = MODE_SAFETY;
                end
            end
            MODE_SAFETY: begin
                if (!relay_level_reg) begin
                    relay_level_next    = 1'b1;
                    retracted_flag_next = 1'b0;
                    retry_due_next      = '0;
                end
                if (!fault) begin
                    // recovery: stop axes and close controller if it was opened, drop relay
                    req_stop               = controller_opened_reg;
                    req_close              = controller_opened_reg;
                    controller_opened_next = 1'b0;
                    retracted_flag_next    = 1'b0;
                    retry_due_next         = '0;
                    attempt_pending_next   = 1'b0;
                    relay_level_next       = 1'b0;
                    mode_next              = MODE_NORMAL;
                end else if (!retracted_flag_next) begin
                    if (attempt_pending_reg) begin
                        if (retract_status == bws_pkg::RetractSuccess) begin
                            retracted_flag_next  = 1'b1;
                            attempt_pending_next = 1'b0;
                        end else if (retract_status == bws_pkg::RetractFailure) begin
                            attempt_pending_next = 1'b0;
                            req_stop             = controller_opened_reg;
                            retry_due_next       = status.tick_count
                                + {{(bws_pkg::TickWidth-bws_pkg::CfgWidth){1'b0}},
                                   retry_interval};
                        end
                    end else if (status.tick_count >= retry_due_next) begin
                        req_retract            = 1'b1;
                        controller_opened_next = 1'b1;
                        attempt_pending_next   = 1'b1;
                    end
                end
            end
            default: begin
                mode_next = MODE_NORMAL;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg              <= MODE_NORMAL;
            relay_level_reg       <= 1'b0;
            retracted_flag_reg    <= 1'b0;
            retry_due_reg         <= '0;
            attempt_pending_reg   <= 1'b0;
            controller_opened_reg <= 1'b0;
        end else if (step) begin
            mode_reg              <= mode_next;
            relay_level_reg       <= relay_level_next;
            retracted_flag_reg    <= retracted_flag_next;
            retry_due_reg         <= retry_due_next;
            attempt_pending_reg   <= attempt_pending_next;
            controller_opened_reg <= controller_opened_next;
        end
    end

    assign result.relay_on         = relay_level_next;
    assign result.safety_mode      = (mode_next == MODE_SAFETY);
    assign result.request_retract  = req_retract;
    assign result.request_stop_all = req_stop;
    assign result.request_close    = req_close;
    assign result.at_safe_position = retracted_flag_next;

    a_relay_only_in_safety: assert property (@(posedge aclk) disable iff (!aresetn)
        relay_level_reg |-> mode_reg == MODE_SAFETY)
        else $error("relay energized outside safety mode");

    a_close_with_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        step && req_close |-> req_stop && !req_retract)
        else $error("close request without stop");

    a_attempt_opens: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(attempt_pending_reg) |-> controller_opened_reg && $past(req_retract))
        else $error("attempt started without retract request");

endmodule

// ===== rtl/core/bus_watchdog_safety_supervisor.sv =====
// top level of the bus watchdog safety supervisor with stream handshakes
//
//  channel   | direction | tdata fields, lowest bit first
//  s_axis    | in        | tick_elapsed, estop_button, bus_frame_seen, retract_status[1:0]
//  m_axis    | out       | relay_on, led_on, safety_mode, estop_active, bus_timeout,
//            |           | request_retract, request_stop_all, request_close, at_safe_position
//  cfg       | in        | write only, index 0..3, 16-bit data
//
//  one transaction per cycle sustained while m_tready stays high; a result is offered once its
//  input has passed the input register, then the result register fed by the timer and mode logic
//  reset clears all supervisor state and loads register defaults 5000, 50, 500, 500
//  while m_tready is low the result holds, one more input is held, then s_tready drops
module bus_watchdog_safety_supervisor (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // tick_elapsed, estop_button, bus_frame_seen, retract_status
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // relay_on, led_on, safety_mode, estop_active, bus_timeout,
                                   // request_retract, request_stop_all, request_close,
                                   // at_safe_position
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);

    logic [bws_pkg::CfgWidth-1:0] timeout_limit_reg;
    logic [bws_pkg::CfgWidth-1:0] release_debounce_reg;
    logic [bws_pkg::CfgWidth-1:0] blink_period_reg;
    logic [bws_pkg::CfgWidth-1:0] retry_interval_reg;

    logic                   in_valid_reg;
    bws_pkg::item_t         in_item_reg;
    logic                   m_valid_reg;
    logic [8:0]             m_data_reg;

    logic                   slot_free;
    logic                   step;
    bws_pkg::timer_status_t timer_status;
    bws_pkg::mode_out_t     mode_result;
    logic [8:0]             result_bits;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_limit_reg    <= bws_pkg::TimeoutLimitReset;
            release_debounce_reg <= bws_pkg::ReleaseDebounceReset;
            blink_period_reg     <= bws_pkg::BlinkPeriodReset;
            retry_interval_reg   <= bws_pkg::RetryIntervalReset;
        end else if (cfg_we) begin
            unique case (bws_pkg::cfg_index_t'(cfg_addr))
                bws_pkg::REG_TIMEOUT_LIMIT:    timeout_limit_reg    <= cfg_wdata;
                bws_pkg::REG_RELEASE_DEBOUNCE: release_debounce_reg <= cfg_wdata;
                bws_pkg::REG_BLINK_PERIOD:     blink_period_reg     <= cfg_wdata;
                bws_pkg::REG_RETRY_INTERVAL:   retry_interval_reg   <= cfg_wdata;
                default:                       timeout_limit_reg    <= timeout_limit_reg;
            endcase
        end
    end

    assign slot_free = !m_valid_reg || m_tready;
    assign step      = in_valid_reg && slot_free;
    assign s_tready  = !in_valid_reg || slot_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (step) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.tick_elapsed   <= s_tdata[0];
            in_item_reg.estop_button   <= s_tdata[1];
            in_item_reg.bus_frame_seen <= s_tdata[2];
            in_item_reg.retract_status <= s_tdata[4:3];
        end
        if (step) begin
            m_data_reg <= result_bits;
        end
    end

    bws_timers u_timers (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .step             (step),
        .item             (in_item_reg),
        .timeout_limit    (timeout_limit_reg),
        .release_debounce (release_debounce_reg),
        .blink_period     (blink_period_reg),
        .status           (timer_status)
    );

    bws_mode u_mode (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step           (step),
        .status         (timer_status),
        .retract_status (in_item_reg.retract_status),
        .retry_interval (retry_interval_reg),
        .result         (mode_result)
    );

    assign result_bits = {mode_result.at_safe_position,
                          mode_result.request_close,
                          mode_result.request_stop_all,
                          mode_result.request_retract,
                          timer_status.timeout_flag,
                          timer_status.stop_latched,
                          mode_result.safety_mode,
                          timer_status.led_level,
                          mode_result.relay_on};

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, m_data_reg};

    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !slot_free |=> in_valid_reg && $stable(in_item_reg))
        else $error("held input lost while output stalled");

    a_step_fills_output: assert property (@(posedge aclk) disable iff (!aresetn)
        step |=> m_valid_reg)
        else $error("processed input produced no result");

    a_ready_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_tready)
        else $error("input refused with empty input stage");

endmodule

// ===== tb/tb.sv =====
// self-checking stream testbench for the bus watchdog safety supervisor with an in-line predictor
`timescale 1ns / 100ps
module tb;

    localparam logic [1:0] RetractReserved = 2'd3;
    localparam int OutFields = 9;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_addr  = '0;
    logic [15:0] cfg_wdata = '0;

    int send_idle_pct = 37;
    int recv_idle_pct = 79;
    int error_count   = 0;

    logic [OutFields-1:0] expected_status_q[$];
    string field_names[OutFields] = '{"relay_on", "led_on", "safety_mode", "estop_active",
        "bus_timeout", "request_retract", "request_stop_all", "request_close",
        "at_safe_position"};

    // supervisor shadow state
    logic [15:0] timeout_limit_r, debounce_r, blink_period_r, retry_interval_r;
    logic [31:0] ticks, release_at, blink_at, retry_at;
    logic [15:0] silence;
    logic        bus_silent, stop_held, led, safety, relay, retracted, attempt_out, ctrl_open;

    bus_watchdog_safety_supervisor dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic logic [OutFields-1:0] advance_supervisor(input bws_pkg::item_t it);
        logic        req_retract, req_stop, req_close;
        logic [31:0] span;
        req_retract = 1'b0;
        req_stop    = 1'b0;
        req_close   = 1'b0;
        if (it.tick_elapsed) begin
            ticks   = ticks + 32'd1;
            silence = silence + 16'd1;
            if (silence >= timeout_limit_r) begin
                silence    = timeout_limit_r;
                bus_silent = 1'b1;
            end
        end
        if (it.estop_button) begin
            stop_held  = 1'b1;
            release_at = ticks;
        end else begin
            span = ticks - release_at;
            if (span >= 32'(debounce_r)) stop_held = 1'b0;
        end
        if (stop_held) begin
            span = ticks - blink_at;
            if (span >= 32'(blink_period_r)) begin
                blink_at = ticks;
                led      = !led;
            end
        end else begin
            led = 1'b1;
        end
        if (it.bus_frame_seen) begin
            silence    = '0;
            bus_silent = 1'b0;
        end
        if (!safety) begin
            if (stop_held || bus_silent) safety = 1'b1;
        end else begin
            if (!relay) begin
                relay     = 1'b1;
                retracted = 1'b0;
                retry_at  = '0;
            end
            if (!stop_held && !bus_silent) begin
                if (ctrl_open) begin
                    req_stop  = 1'b1;
                    req_close = 1'b1;
                end
                ctrl_open   = 1'b0;
                retracted   = 1'b0;
                retry_at    = '0;
                attempt_out = 1'b0;
                relay       = 1'b0;
                safety      = 1'b0;
            end else if (!retracted) begin
                if (attempt_out) begin
                    if (it.retract_status == bws_pkg::RetractSuccess) begin
                        retracted   = 1'b1;
                        attempt_out = 1'b0;
                    end else if (it.retract_status == bws_pkg::RetractFailure) begin
                        attempt_out = 1'b0;
                        if (ctrl_open) req_stop = 1'b1;
                        retry_at = ticks + 32'(retry_interval_r);
                    end
                end else if (ticks >= retry_at) begin
                    req_retract = 1'b1;
                    ctrl_open   = 1'b1;
                    attempt_out = 1'b1;
                end
            end
        end
        return {retracted, req_close, req_stop, req_retract, bus_silent, stop_held, safety,
                led, relay};
    endfunction

    // input transaction monitor feeds the predictor
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            expected_status_q.push_back(advance_supervisor(
                bws_pkg::item_t'({s_tdata[0], s_tdata[1], s_tdata[2], s_tdata[4:3]})));
    end

    always @(posedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin : result_check
        logic [OutFields-1:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_status_q.size() == 0) begin
                $display("%0t: result %h with none expected", $time, m_tdata);
                error_count++;
            end else begin
                want = expected_status_q.pop_front();
                for (int i = 0; i < OutFields; i++) begin
                    if (m_tdata[i] !== want[i]) begin
                        $display("%0t: %s expected %0b actual %0b", $time, field_names[i],
                                 want[i], m_tdata[i]);
                        error_count++;
                    end
                end
                if (m_tdata[15:OutFields] !== '0) begin
                    $display("%0t: padding expected 0 actual %h", $time, m_tdata[15:OutFields]);
                    error_count++;
                end
            end
        end
    end

    task automatic send_item(input bws_pkg::item_t it);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, it.retract_status, it.bus_frame_seen, it.estop_button,
                     it.tick_elapsed};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_status_q.size() != 0) @(posedge aclk);
    endtask

    task automatic write_register(input bws_pkg::cfg_index_t idx, input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            bws_pkg::REG_TIMEOUT_LIMIT:    timeout_limit_r  = value;
            bws_pkg::REG_RELEASE_DEBOUNCE: debounce_r       = value;
            bws_pkg::REG_BLINK_PERIOD:     blink_period_r   = value;
            bws_pkg::REG_RETRY_INTERVAL:   retry_interval_r = value;
            default: ;
        endcase
    endtask

    task automatic write_all_registers(input logic [15:0] tl, input logic [15:0] db,
                                       input logic [15:0] bp, input logic [15:0] ri);
        wait_drained();
        write_register(bws_pkg::REG_TIMEOUT_LIMIT, tl);
        write_register(bws_pkg::REG_RELEASE_DEBOUNCE, db);
        write_register(bws_pkg::REG_BLINK_PERIOD, bp);
        write_register(bws_pkg::REG_RETRY_INTERVAL, ri);
    endtask

    function automatic bws_pkg::item_t random_item(input int tick_pct, input int press_pct,
                                                   input int frame_pct);
        bws_pkg::item_t it;
        int             pick;
        it.tick_elapsed   = ($urandom_range(99) < tick_pct);
        it.estop_button   = ($urandom_range(99) < press_pct);
        it.bus_frame_seen = ($urandom_range(99) < frame_pct);
        pick = $urandom_range(99);
        if (pick < 45) it.retract_status = bws_pkg::RetractNone;
        else if (pick < 70) it.retract_status = bws_pkg::RetractSuccess;
        else if (pick < 95) it.retract_status = bws_pkg::RetractFailure;
        else it.retract_status = RetractReserved;
        return it;
    endfunction

    task automatic test_default_registers();
        send_item('{1'b0, 1'b0, 1'b0, bws_pkg::RetractNone});
        send_item('{1'b1, 1'b0, 1'b0, bws_pkg::RetractNone});
        send_item('{1'b1, 1'b0, 1'b1, bws_pkg::RetractSuccess});
        send_item('{1'b0, 1'b1, 1'b0, bws_pkg::RetractNone});
        send_item('{1'b1, 1'b1, 1'b0, bws_pkg::RetractNone});
        send_item('{1'b1, 1'b0, 1'b0, RetractReserved});
        send_item('{1'b1, 1'b0, 1'b0, bws_pkg::RetractFailure});
        send_item('{1'b1, 1'b1, 1'b1, bws_pkg::RetractFailure});
    endtask

    task automatic test_recovery_paths();
        write_all_registers(16'd2, 16'd2, 16'd2, 16'd2);
        repeat (3) send_item('{1'b1, 1'b0, 1'b1, bws_pkg::RetractNone});
        send_item('{1'b0, 1'b1, 1'b0, bws_pkg::RetractNone});
        send_item('{1'b0, 1'b1, 1'b0, bws_pkg::RetractNone});
        send_item('{1'b1, 1'b1, 1'b0, bws_pkg::RetractSuccess});
        repeat (3) send_item('{1'b1, 1'b0, 1'b1, bws_pkg::RetractNone});
        repeat (3) send_item('{1'b1, 1'b0, 1'b0, bws_pkg::RetractNone});
        send_item('{1'b0, 1'b0, 1'b0, bws_pkg::RetractNone});
        send_item('{1'b1, 1'b0, 1'b0, bws_pkg::RetractFailure});
        repeat (3) send_item('{1'b1, 1'b0, 1'b0, bws_pkg::RetractNone});
    endtask

    task automatic test_register_extremes();
        write_all_registers(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        repeat (3) send_item(random_item(80, 20, 20));
        write_all_registers(16'd0, 16'd0, 16'd0, 16'd0);
        repeat (4) send_item(random_item(80, 30, 20));
        write_all_registers(16'd1, 16'd1, 16'd1, 16'd1);
        repeat (4) send_item(random_item(80, 30, 20));
    endtask

    task automatic test_random_traffic(input int n_items);
        int sent;
        int seg_left;
        int tick_pct, press_pct, frame_pct;
        write_all_registers(16'($urandom_range(1, 24)), 16'($urandom_range(1, 12)),
                            16'($urandom_range(1, 8)), 16'($urandom_range(1, 12)));
        sent = 0;
        seg_left = 0;
        while (sent < n_items) begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(20, 60);
                tick_pct = $urandom_range(30, 100);
                case ($urandom_range(2))
                    0: press_pct = 0;
                    1: press_pct = 5;
                    default: press_pct = 40;
                endcase
                case ($urandom_range(2))
                    0: frame_pct = 2;
                    1: frame_pct = 20;
                    default: frame_pct = 70;
                endcase
            end
            send_item(random_item(tick_pct, press_pct, frame_pct));
            seg_left--;
            sent++;
        end
    endtask

    initial begin
        timeout_limit_r  = bws_pkg::TimeoutLimitReset;
        debounce_r       = bws_pkg::ReleaseDebounceReset;
        blink_period_r   = bws_pkg::BlinkPeriodReset;
        retry_interval_r = bws_pkg::RetryIntervalReset;
        ticks = '0; release_at = '0; blink_at = '0; retry_at = '0; silence = '0;
        bus_silent = 0; stop_held = 0; led = 0; safety = 0;
        relay = 0; retracted = 0; attempt_out = 0; ctrl_open = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_default_registers();
        test_recovery_paths();
        test_register_extremes();
        test_random_traffic(200);
        send_idle_pct = 79;
        recv_idle_pct = 37;
        test_random_traffic(200);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(200);

        wait_drained();
        repeat (4) @(posedge aclk);
        if (error_count == 0 && expected_status_q.size() == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end

    initial begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
